// ----- hdl/sdtq_pkg.sv -----
// Package for the sorted deadline timer queue.
// Holds command and status codes and the fixed field widths.
// No dependencies.
package sdtq_pkg;
    localparam int CMD_W    = 2;
    localparam int TIME_W   = 64;
    localparam int TGT_W    = 8;
    localparam int STATUS_W = 3;
    localparam int TID_W    = 7;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [TIME_W-1:0]   t_time;

    localparam t_cmd CMD_REGISTER = 2'd0;
    localparam t_cmd CMD_REMOVE   = 2'd1;
    localparam t_cmd CMD_TICK     = 2'd2;

    localparam t_status ST_REGISTERED  = 3'd0;
    localparam t_status ST_FULL        = 3'd1;
    localparam t_status ST_REMOVED     = 3'd2;
    localparam t_status ST_REMOVE_FAIL = 3'd3;
    localparam t_status ST_EXPIRED     = 3'd4;
endpackage

// ----- hdl/sdtq_if.sv -----
// Valid/ready channel interfaces for the timer queue command and result.
// Depends on sdtq_pkg.
interface sdtq_req_if;
    logic               valid;
    logic               ready;
    sdtq_pkg::t_cmd     cmd;
    sdtq_pkg::t_time    now_us;
    sdtq_pkg::t_time    delay_us;
    logic [sdtq_pkg::TGT_W-1:0] target_id;

    modport source (output valid, cmd, now_us, delay_us, target_id, input ready);
    modport sink (input valid, cmd, now_us, delay_us, target_id, output ready);
endinterface

interface sdtq_rsp_if;
    logic               valid;
    logic               ready;
    sdtq_pkg::t_status  status;
    logic [sdtq_pkg::TID_W-1:0] timer_id;
    logic               last;

    modport source (output valid, status, timer_id, last, input ready);
    modport sink (input valid, status, timer_id, last, output ready);
endinterface

// ----- hdl/sdtq_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sdtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/sorted_deadline_timer_queue_unit.sv -----
// Sorted deadline timer queue: deadline and id tables in RAM, one sequencer.
// One command at a time; each step of a register, remove or tick takes a read
// state and then a check or write state, as the RAM read is registered; output
// stalls hold the sequencer. After reset an init sweep loads the id table; no
// command is taken until it ends. Depends on sdtq_pkg, sdtq_if and sdtq_ram.
module sorted_deadline_timer_queue_unit #(
    parameter int N_TIMERS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdtq_req_if.sink   i_req,
    sdtq_rsp_if.source o_rsp
);
    localparam int AW = $clog2(N_TIMERS);
    localparam int PW = $clog2(N_TIMERS + 1);
    localparam int IW = PW;
    localparam int CW = (IW > sdtq_pkg::TGT_W) ? IW : sdtq_pkg::TGT_W;

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_EMIT   = 5'd2;
    localparam logic [4:0] S_RG_ID  = 5'd3;
    localparam logic [4:0] S_RG_NEW = 5'd4;
    localparam logic [4:0] S_RG_RD  = 5'd5;
    localparam logic [4:0] S_RG_CHK = 5'd6;
    localparam logic [4:0] S_RG_PUT = 5'd7;
    localparam logic [4:0] S_RM_RD  = 5'd8;
    localparam logic [4:0] S_RM_CHK = 5'd9;
    localparam logic [4:0] S_SH_RD  = 5'd10;
    localparam logic [4:0] S_SH_WR  = 5'd11;
    localparam logic [4:0] S_TK_RD  = 5'd12;
    localparam logic [4:0] S_TK_CHK = 5'd13;
    localparam logic [4:0] S_TK_END = 5'd14;
    localparam logic [4:0] S_CP_RD  = 5'd15;
    localparam logic [4:0] S_CP_WR  = 5'd16;
    localparam logic [4:0] S_RS_RD  = 5'd17;
    localparam logic [4:0] S_RS_WR  = 5'd18;

    logic [4:0]    r_state, n_state;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [PW-1:0] r_live, n_live;
    logic [PW-1:0] r_k, n_k;
    sdtq_pkg::t_time r_now, n_now;
    sdtq_pkg::t_time r_dnew, n_dnew;
    logic [sdtq_pkg::TGT_W-1:0] r_tgt, n_tgt;
    logic [IW-1:0] r_nid, n_nid;
    logic          r_pend, n_pend;
    logic [IW-1:0] r_pid, n_pid;
    sdtq_pkg::t_status r_est, n_est;
    logic [IW-1:0] r_eid, n_eid;
    logic          r_ov, n_ov;
    sdtq_pkg::t_status r_ost, n_ost;
    logic [sdtq_pkg::TID_W-1:0] r_oid, n_oid;
    logic          r_olast, n_olast;

    logic              dl_we;
    logic [AW-1:0]     dl_waddr, dl_raddr;
    sdtq_pkg::t_time   dl_wdata, dl_rdata;
    logic              id_we;
    logic [AW:0]       id_waddr, id_raddr;
    logic [IW-1:0]     id_wdata, id_rdata;
    logic              can_emit;
    logic [PW-1:0]     ptr_p1;

    sdtq_ram #(.WIDTH(sdtq_pkg::TIME_W), .DEPTH(N_TIMERS)) u_dl_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (dl_waddr),
        .i_wdata (dl_wdata),
        .i_raddr (dl_raddr),
        .o_rdata (dl_rdata)
    );

    sdtq_ram #(.WIDTH(IW), .DEPTH(2 * N_TIMERS)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (id_we),
        .i_waddr (id_waddr),
        .i_wdata (id_wdata),
        .i_raddr (id_raddr),
        .o_rdata (id_rdata)
    );

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_ov;
    assign o_rsp.status = r_ost;
    assign o_rsp.timer_id = r_oid;
    assign o_rsp.last   = r_olast;
    assign can_emit = !r_ov || o_rsp.ready;
    assign ptr_p1   = r_ptr + PW'(1);

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_live  = r_live;
        n_k     = r_k;
        n_now   = r_now;
        n_dnew  = r_dnew;
        n_tgt   = r_tgt;
        n_nid   = r_nid;
        n_pend  = r_pend;
        n_pid   = r_pid;
        n_est   = r_est;
        n_eid   = r_eid;
        n_ov    = r_ov && !o_rsp.ready;
        n_ost   = r_ost;
        n_oid   = r_oid;
        n_olast = r_olast;
        dl_we    = 1'b0;
        dl_waddr = r_ptr[AW-1:0];
        dl_wdata = dl_rdata;
        dl_raddr = r_ptr[AW-1:0];
        id_we    = 1'b0;
        id_waddr = {1'b0, r_ptr[AW-1:0]};
        id_wdata = id_rdata;
        id_raddr = {1'b0, r_ptr[AW-1:0]};

        case (r_state)
            S_INIT: begin
                id_we    = 1'b1;
                id_wdata = IW'(ptr_p1);
                n_ptr    = ptr_p1;
                if (ptr_p1 == PW'(N_TIMERS)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_now  = i_req.now_us;
                    n_dnew = i_req.now_us + i_req.delay_us;
                    n_tgt  = i_req.target_id;
                    n_ptr  = '0;
                    n_pend = 1'b0;
                    n_eid  = '0;
                    case (i_req.cmd)
                        sdtq_pkg::CMD_REGISTER: begin
                            if (r_live == PW'(N_TIMERS)) begin
                                n_est   = sdtq_pkg::ST_FULL;
                                n_state = S_EMIT;
                            end else begin
                                n_ptr   = r_live;
                                n_state = S_RG_ID;
                            end
                        end
                        sdtq_pkg::CMD_REMOVE: begin
                            if (i_req.target_id == '0
                                || int'(i_req.target_id) > N_TIMERS) begin
                                n_est   = sdtq_pkg::ST_REMOVE_FAIL;
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_RM_RD;
                            end
                        end
                        sdtq_pkg::CMD_TICK: begin
                            n_state = S_TK_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (can_emit) begin
                    n_ov    = 1'b1;
                    n_ost   = r_est;
                    n_oid   = sdtq_pkg::TID_W'(r_eid);
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RG_ID: begin
                n_state = S_RG_NEW;
            end
            S_RG_NEW: begin
                n_nid = id_rdata;
                if (r_live == '0) begin
                    n_ptr   = '0;
                    n_state = S_RG_PUT;
                end else begin
                    n_ptr   = r_live - PW'(1);
                    n_state = S_RG_RD;
                end
            end
            S_RG_RD: begin
                n_state = S_RG_CHK;
            end
            S_RG_CHK: begin
                if (dl_rdata > r_dnew) begin
                    dl_we    = 1'b1;
                    id_we    = 1'b1;
                    dl_waddr = ptr_p1[AW-1:0];
                    id_waddr = {1'b0, ptr_p1[AW-1:0]};
                    if (r_ptr == '0) begin
                        n_state = S_RG_PUT;
                    end else begin
                        n_ptr   = r_ptr - PW'(1);
                        n_state = S_RG_RD;
                    end
                end else begin
                    n_ptr   = ptr_p1;
                    n_state = S_RG_PUT;
                end
            end
            S_RG_PUT: begin
                dl_we    = 1'b1;
                id_we    = 1'b1;
                dl_wdata = r_dnew;
                id_wdata = r_nid;
                n_live   = r_live + PW'(1);
                n_est    = sdtq_pkg::ST_REGISTERED;
                n_eid    = r_nid;
                n_state  = S_EMIT;
            end
            S_RM_RD: begin
                if (r_ptr == r_live) begin
                    n_est   = sdtq_pkg::ST_REMOVE_FAIL;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_RM_CHK;
                end
            end
            S_RM_CHK: begin
                if (CW'(id_rdata) == CW'(r_tgt)) begin
                    n_state = S_SH_RD;
                end else begin
                    n_ptr   = ptr_p1;
                    n_state = S_RM_RD;
                end
            end
            S_SH_RD: begin
                dl_raddr = ptr_p1[AW-1:0];
                id_raddr = {1'b0, ptr_p1[AW-1:0]};
                if (ptr_p1 >= r_live) begin
                    id_we    = 1'b1;
                    id_waddr = {1'b0, r_ptr[AW-1:0]};
                    id_wdata = IW'(r_tgt);
                    n_live   = r_live - PW'(1);
                    n_est    = sdtq_pkg::ST_REMOVED;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                dl_we   = 1'b1;
                id_we   = 1'b1;
                n_ptr   = ptr_p1;
                n_state = S_SH_RD;
            end
            S_TK_RD: begin
                if (r_ptr == r_live) begin
                    n_state = S_TK_END;
                end else begin
                    n_state = S_TK_CHK;
                end
            end
            S_TK_CHK: begin
                if (dl_rdata > r_now) begin
                    n_state = S_TK_END;
                end else if (!r_pend || can_emit) begin
                    if (r_pend) begin
                        n_ov    = 1'b1;
                        n_ost   = sdtq_pkg::ST_EXPIRED;
                        n_oid   = sdtq_pkg::TID_W'(r_pid);
                        n_olast = 1'b0;
                    end
                    id_we    = 1'b1;
                    id_waddr = (AW + 1)'(N_TIMERS) + {1'b0, r_ptr[AW-1:0]};
                    n_pid    = id_rdata;
                    n_pend   = 1'b1;
                    n_ptr    = ptr_p1;
                    n_state  = S_TK_RD;
                end
            end
            S_TK_END: begin
                if (!r_pend) begin
                    n_state = S_IDLE;
                end else if (can_emit) begin
                    n_ov    = 1'b1;
                    n_ost   = sdtq_pkg::ST_EXPIRED;
                    n_oid   = sdtq_pkg::TID_W'(r_pid);
                    n_olast = 1'b1;
                    n_pend  = 1'b0;
                    n_k     = r_ptr;
                    n_state = S_CP_RD;
                end
            end
            S_CP_RD: begin
                if (r_ptr == r_live) begin
                    n_ptr   = '0;
                    n_state = S_RS_RD;
                end else begin
                    n_state = S_CP_WR;
                end
            end
            S_CP_WR: begin
                dl_we    = 1'b1;
                id_we    = 1'b1;
                dl_waddr = AW'(r_ptr - r_k);
                id_waddr = {1'b0, AW'(r_ptr - r_k)};
                n_ptr    = ptr_p1;
                n_state  = S_CP_RD;
            end
            S_RS_RD: begin
                id_raddr = (AW + 1)'(N_TIMERS) + {1'b0, r_ptr[AW-1:0]};
                if (r_ptr == r_k) begin
                    n_live  = r_live - r_k;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RS_WR;
                end
            end
            S_RS_WR: begin
                id_we    = 1'b1;
                id_waddr = {1'b0, AW'(r_live - r_k + r_ptr)};
                n_ptr    = ptr_p1;
                n_state  = S_RS_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr   <= '0;
            r_live  <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_live  <= n_live;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
        r_k     <= n_k;
        r_now   <= n_now;
        r_dnew  <= n_dnew;
        r_tgt   <= n_tgt;
        r_nid   <= n_nid;
        r_pid   <= n_pid;
        r_est   <= n_est;
        r_eid   <= n_eid;
        r_ost   <= n_ost;
        r_oid   <= n_oid;
        r_olast <= n_olast;
    end
endmodule

// ----- tb/sv/sorted_deadline_timer_queue_unit_tb.sv -----
// Testbench for the sorted deadline timer queue: directed and random
// command traffic, with results checked against an in-bench timer table.
// Depends on sdtq_pkg, sdtq_if and sorted_deadline_timer_queue_unit.
`timescale 1ns / 1ps

module sorted_deadline_timer_queue_unit_tb;
    localparam int NT = 64;
    localparam longint MAX_CYCLES = 3000000;

    typedef struct packed {
        sdtq_pkg::t_status status;
        logic [6:0]        timer_id;
        logic              last;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;
    sdtq_req_if req ();
    sdtq_rsp_if rsp ();

    sorted_deadline_timer_queue_unit #(.N_TIMERS(NT)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    sdtq_pkg::t_time slot_deadline [NT];
    logic [7:0] slot_id       [NT];
    int         live;
    t_outcome   pending_outcomes [$];
    int         errors;
    longint     cycle_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_off;
    sdtq_pkg::t_time clock_now;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("sorted_deadline_timer_queue_unit_tb: errors");
            $finish;
        end
    end

    task automatic predict_timer_cmd(input sdtq_pkg::t_cmd cmd, input sdtq_pkg::t_time now,
                                     input sdtq_pkg::t_time dly, input logic [7:0] tgt);
        int i;
        int k;
        sdtq_pkg::t_time td;
        logic [7:0] ti;
        logic [7:0] gone [NT];
        case (cmd)
            sdtq_pkg::CMD_REGISTER: begin
                if (live >= NT) begin
                    pending_outcomes.push_back('{sdtq_pkg::ST_FULL, 7'd0, 1'b1});
                end else begin
                    i = live;
                    slot_deadline[i] = now + dly;
                    pending_outcomes.push_back('{sdtq_pkg::ST_REGISTERED, slot_id[i][6:0],
                                                 1'b1});
                    live++;
                    while (i > 0 && slot_deadline[i] < slot_deadline[i-1]) begin
                        td = slot_deadline[i]; ti = slot_id[i];
                        slot_deadline[i] = slot_deadline[i-1]; slot_id[i] = slot_id[i-1];
                        slot_deadline[i-1] = td; slot_id[i-1] = ti;
                        i--;
                    end
                end
            end
            sdtq_pkg::CMD_REMOVE: begin
                i = 0;
                while (i < live && slot_id[i] != tgt) i++;
                if (tgt == 0 || tgt > NT || i >= live) begin
                    pending_outcomes.push_back('{sdtq_pkg::ST_REMOVE_FAIL, 7'd0, 1'b1});
                end else begin
                    ti = slot_id[i];
                    for (; i + 1 < live; i++) begin
                        slot_deadline[i] = slot_deadline[i+1];
                        slot_id[i] = slot_id[i+1];
                    end
                    slot_id[live-1] = ti;
                    live--;
                    pending_outcomes.push_back('{sdtq_pkg::ST_REMOVED, 7'd0, 1'b1});
                end
            end
            sdtq_pkg::CMD_TICK: begin
                k = 0;
                while (k < live && slot_deadline[k] <= now) begin
                    gone[k] = slot_id[k];
                    k++;
                end
                for (i = 0; i < k; i++)
                    pending_outcomes.push_back('{sdtq_pkg::ST_EXPIRED, gone[i][6:0],
                                                 i == k - 1});
                if (k > 0) begin
                    for (i = k; i < live; i++) begin
                        slot_deadline[i-k] = slot_deadline[i];
                        slot_id[i-k] = slot_id[i];
                    end
                    for (i = 0; i < k; i++) slot_id[live-k+i] = gone[i];
                    live -= k;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_cmd(input sdtq_pkg::t_cmd cmd, input sdtq_pkg::t_time now,
                            input sdtq_pkg::t_time dly, input logic [7:0] tgt);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid     <= 1'b1;
        req.cmd       <= cmd;
        req.now_us    <= now;
        req.delay_us  <= dly;
        req.target_id <= tgt;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        predict_timer_cmd(cmd, now, dly, tgt);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t unexpected result status=%0d id=%0d last=%0d", $realtime,
                             rsp.status, rsp.timer_id, rsp.last);
                    errors++;
                end else begin
                    if (rsp.status !== pending_outcomes[0].status
                        || rsp.timer_id !== pending_outcomes[0].timer_id
                        || rsp.last !== pending_outcomes[0].last) begin
                        $display({"%0t mismatch: expected status=%0d id=%0d last=%0d,",
                                  " got %0d %0d %0d"},
                                 $realtime, pending_outcomes[0].status,
                                 pending_outcomes[0].timer_id, pending_outcomes[0].last,
                                 rsp.status, rsp.timer_id, rsp.last);
                        errors++;
                    end
                    void'(pending_outcomes.pop_front());
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic sdtq_pkg::t_time rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pick_live_id();
        if (live == 0) return 8'($urandom_range(1, NT));
        return slot_id[$urandom_range(live - 1)];
    endfunction

    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_cmd(sdtq_pkg::CMD_TICK, 64'd0, 64'd0, 8'd0);
        send_cmd(sdtq_pkg::CMD_REMOVE, 64'd0, 64'd0, 8'd0);
        send_cmd(sdtq_pkg::CMD_REMOVE, 64'd0, 64'd0, 8'd65);
        send_cmd(sdtq_pkg::CMD_REMOVE, 64'd0, 64'd0, 8'd255);
        send_cmd(sdtq_pkg::CMD_REMOVE, 64'd0, 64'd0, 8'd5);
        send_cmd(sdtq_pkg::CMD_REGISTER, 64'd100, 64'd50, 8'd0);
        send_cmd(sdtq_pkg::CMD_REGISTER, 64'd100, 64'd50, 8'd0);
        send_cmd(sdtq_pkg::CMD_REGISTER, 64'd10, 64'd0, 8'd0);
        send_cmd(sdtq_pkg::CMD_REGISTER, '1, 64'd2, 8'd0);
        send_cmd(sdtq_pkg::CMD_REGISTER, '1, '1, 8'd0);
        send_cmd(sdtq_pkg::CMD_REGISTER, 64'd0, 64'd0, 8'd0);
        send_cmd(sdtq_pkg::CMD_REMOVE, 64'd0, 64'd0, 8'd2);
        send_cmd(sdtq_pkg::CMD_REMOVE, 64'd0, 64'd0, 8'd2);
        send_cmd(2'd3, '1, '1, 8'hff);
        send_cmd(sdtq_pkg::CMD_TICK, 64'd150, 64'd0, 8'd0);
        send_cmd(sdtq_pkg::CMD_TICK, '1, 64'd0, 8'd0);
        send_cmd(sdtq_pkg::CMD_TICK, 64'd0, 64'd0, 8'd0);
        wait_drained();
    endtask

    task automatic test_table_full();
        int n;
        for (n = 0; n < NT + 2; n++)
            send_cmd(sdtq_pkg::CMD_REGISTER, 64'd1000, 64'($urandom_range(50)), 8'd0);
        send_cmd(sdtq_pkg::CMD_REMOVE, 64'd0, 64'd0, 8'd64);
        send_cmd(sdtq_pkg::CMD_REGISTER, 64'd0, 64'd0, 8'd0);
        send_cmd(sdtq_pkg::CMD_TICK, '1, 64'd0, 8'd0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        int n;
        int r;
        for (n = 0; n < count; n++) begin
            r = $urandom_range(99);
            clock_now = clock_now + 64'($urandom_range(40));
            if (r < 45)
                send_cmd(sdtq_pkg::CMD_REGISTER,
                         ($urandom_range(9) == 0) ? rand64() : clock_now,
                         ($urandom_range(7) == 0) ? rand64() : 64'($urandom_range(200)),
                         8'd0);
            else if (r < 65)
                send_cmd(sdtq_pkg::CMD_REMOVE, rand64(), rand64(),
                         ($urandom_range(3) == 0) ? 8'($urandom) : pick_live_id());
            else if (r < 95)
                send_cmd(sdtq_pkg::CMD_TICK, ($urandom_range(19) == 0) ? rand64() : clock_now,
                         rand64(), 8'($urandom));
            else
                send_cmd(2'd3, rand64(), rand64(), 8'($urandom));
        end
    endtask

    task automatic test_backpressure();
        int n;
        hold_off = 400;
        for (n = 0; n < 20; n++)
            send_cmd(sdtq_pkg::CMD_REGISTER, clock_now, 64'($urandom_range(30)), 8'd0);
        send_cmd(sdtq_pkg::CMD_TICK, clock_now + 64'd40, 64'd0, 8'd0);
        wait_drained();
    endtask

    initial begin
        int i;
        errors = 0; cycle_count = 0; hold_off = 0; live = 0; clock_now = 64'd0;
        send_idle_pct = 0; recv_idle_pct = 0;
        for (i = 0; i < NT; i++) begin
            slot_id[i] = 8'(i + 1);
            slot_deadline[i] = '0;
        end
        i_rst_n = 1'b0;
        req.valid = 1'b0; req.cmd = sdtq_pkg::CMD_TICK; req.now_us = '0; req.delay_us = '0;
        req.target_id = '0; rsp.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        send_idle_pct = 7; recv_idle_pct = 65;
        test_random_traffic(125);
        test_backpressure();
        send_idle_pct = 65; recv_idle_pct = 7;
        test_random_traffic(125);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_traffic(125);
        wait_drained();
        repeat (400) @(posedge i_clk);
        if (errors == 0 && pending_outcomes.size() == 0) begin
            $display("sorted_deadline_timer_queue_unit_tb: clean");
        end else begin
            $display("sorted_deadline_timer_queue_unit_tb: errors");
        end
        $finish;
    end
endmodule
